/* rtl/core/indexed_max_heap_queue_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the indexed max-heap queue
// Shared concurrent assertion shorthands, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef INDEXED_MAX_HEAP_QUEUE_TOP_MACROS_SVH
`define INDEXED_MAX_HEAP_QUEUE_TOP_MACROS_SVH

// condition holds at every edge out of reset
`define IMHQ_ASSERT_HOLDS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define IMHQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/imhq_pkg.sv */
// ----------------------------------------------------------------------------
// imhq_pkg
// Shared codes, defaults and controller/datapath status type.
// ----------------------------------------------------------------------------
package imhq_pkg;

   localparam int DEF_HEAP_DEPTH = 256;
   localparam int DEF_ITEM_COUNT = 256;
   localparam int DEF_KEY_BITS   = 32;

   localparam int ITEM_W = 8;
   localparam int OP_W   = 2;
   localparam int STS_W  = 3;
   localparam int STEP_W = 4;

   // operations
   localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
   localparam logic [OP_W-1:0] OP_EXTRACT = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE  = 2'd2;
   localparam logic [OP_W-1:0] OP_UPDATE  = 2'd3;

   // result status
   localparam logic [STS_W-1:0] ST_OK      = 3'd0;
   localparam logic [STS_W-1:0] ST_EMPTY   = 3'd1;
   localparam logic [STS_W-1:0] ST_FULL    = 3'd2;
   localparam logic [STS_W-1:0] ST_ABSENT  = 3'd3;
   localparam logic [STS_W-1:0] ST_PRESENT = 3'd4;

   // datapath step commands
   localparam logic [STEP_W-1:0] STEP_NONE    = 4'd0;
   localparam logic [STEP_W-1:0] STEP_CAPTURE = 4'd1;
   localparam logic [STEP_W-1:0] STEP_SETUP   = 4'd2;
   localparam logic [STEP_W-1:0] STEP_FETCH   = 4'd3;
   localparam logic [STEP_W-1:0] STEP_UP_RD   = 4'd4;
   localparam logic [STEP_W-1:0] STEP_UP_CMP  = 4'd5;
   localparam logic [STEP_W-1:0] STEP_DN_RD   = 4'd6;
   localparam logic [STEP_W-1:0] STEP_DN_CMP  = 4'd7;
   localparam logic [STEP_W-1:0] STEP_PLACE   = 4'd8;

   typedef struct packed {
      logic err;         // request rejected
      logic is_insert;
      logic fetch_done;  // removed entry was the last slot, nothing to sift
      logic sift_up;
      logic at_top;      // hole is the root
      logic at_leaf;     // hole has no left child
      logic up_move;     // parent moves down into the hole
      logic dn_move;     // a child moves up into the hole
   } imhq_sts_type;

endpackage

/* rtl/core/indexed_max_heap_queue_top.sv */
// ----------------------------------------------------------------------------
// indexed_max_heap_queue_top
// Indexed binary max-heap of (item id, key) entries with a position table.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel (req_*): one beat carries op, item_id and key. A beat is
//    taken when req_valid is high and req_stall low. req_stall stays high
//    from the accepted beat until its result beat has been taken.
//  - Result channel (rsp_*): exactly one beat per request with status,
//    out_item, out_key (zero unless extract or remove succeeded) and
//    entry_total. A stalled result holds until rsp_stall drops.
//  - A rejected request, and a remove of the last slot, skip the heap walk;
//    otherwise each level walked costs a registered read of the slot memory
//    and a compare.
//  - Throughput: one request at a time; the next beat is taken the cycle
//    after the result leaves.
//  - Reset (synchronous): entry count zero and every item marked absent at
//    once; no clearing pass, so a request may follow right after reset.
// ----------------------------------------------------------------------------
module indexed_max_heap_queue_top import imhq_pkg::*; #(
   parameter int HEAP_DEPTH = DEF_HEAP_DEPTH,
   parameter int ITEM_COUNT = DEF_ITEM_COUNT,
   parameter int KEY_BITS   = DEF_KEY_BITS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [1:0]   req_op,
   input  logic [7:0]   req_item_id,
   input  logic [31:0]  req_key,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [2:0]   rsp_status,
   output logic [7:0]   rsp_out_item,
   output logic [31:0]  rsp_out_key,
   output logic [8:0]   rsp_entry_total
);

   imhq_sts_type       sts;
   logic [STEP_W-1:0]  step_code;

   // sequencer: owns the handshake and picks one datapath step per cycle
   imhq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .step_code (step_code)
   );

   // storage and compare logic; result fields are registers held until taken
   imhq_datapath #(
      .HEAP_DEPTH (HEAP_DEPTH),
      .ITEM_COUNT (ITEM_COUNT),
      .KEY_BITS   (KEY_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .step_code       (step_code),
      .req_op          (req_op),
      .req_item_id     (req_item_id),
      .req_key         (req_key),
      .sts             (sts),
      .rsp_status      (rsp_status),
      .rsp_out_item    (rsp_out_item),
      .rsp_out_key     (rsp_out_key),
      .rsp_entry_total (rsp_entry_total)
   );

endmodule

/* rtl/core/imhq_datapath.sv */
// ----------------------------------------------------------------------------
// imhq_datapath
// Heap slot memory, position table, entry count and hole-based sift logic.
// ----------------------------------------------------------------------------
`include "indexed_max_heap_queue_top_macros.svh"

module imhq_datapath import imhq_pkg::*; #(
   parameter int HEAP_DEPTH = DEF_HEAP_DEPTH,
   parameter int ITEM_COUNT = DEF_ITEM_COUNT,
   parameter int KEY_BITS   = DEF_KEY_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [STEP_W-1:0]  step_code,
   input  logic [OP_W-1:0]    req_op,
   input  logic [7:0]         req_item_id,
   input  logic [31:0]        req_key,
   output imhq_sts_type       sts,
   output logic [2:0]         rsp_status,
   output logic [7:0]         rsp_out_item,
   output logic [31:0]        rsp_out_key,
   output logic [8:0]         rsp_entry_total
);

   localparam int AW = $clog2(HEAP_DEPTH);
   localparam int CW = $clog2(HEAP_DEPTH + 1);
   localparam int PD = (ITEM_COUNT < 256) ? ITEM_COUNT : 256;
   localparam int IW = $clog2(PD);
   localparam int SW = ITEM_W + KEY_BITS;
   localparam int XW = AW + 2;

   logic [SW-1:0]       slot_mem [HEAP_DEPTH];
   logic [AW-1:0]       pos_mem  [PD];
   logic [PD-1:0]       pos_vld_ff;

   logic [OP_W-1:0]     op_ff;
   logic [ITEM_W-1:0]   item_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic                id_ok_ff;
   logic [AW-1:0]       pos_rd_ff;
   logic                pos_hit_ff;
   logic [CW-1:0]       count_ff, count_in;
   logic [AW-1:0]       hole_ff, hole_in;
   logic [KEY_BITS-1:0] cur_key_ff;
   logic [ITEM_W-1:0]   cur_item_ff;
   logic [STS_W-1:0]    status_ff;
   logic [ITEM_W-1:0]   out_item_ff;
   logic [KEY_BITS-1:0] out_key_ff;
   logic [SW-1:0]       rd_a_ff, rd_b_ff;

   logic [KEY_BITS-1:0] a_key, b_key;
   logic [ITEM_W-1:0]   a_item;
   logic [AW-1:0]       last_slot, parent;
   logic [XW-1:0]       left, right, cnt_x;
   logic                r_ok, l_gt, pick_r;
   logic [STS_W-1:0]    err_code;
   logic                rd_en;
   logic [AW-1:0]       addr_a, addr_b;
   logic                slot_we;
   logic [SW-1:0]       slot_wd;

   assign a_key     = rd_a_ff[KEY_BITS-1:0];
   assign a_item    = rd_a_ff[SW-1:KEY_BITS];
   assign b_key     = rd_b_ff[KEY_BITS-1:0];
   assign last_slot = AW'(count_ff - CW'(1));
   assign parent    = AW'((hole_ff - AW'(1)) >> 1);
   assign left      = {1'b0, hole_ff, 1'b1};
   assign right     = left + XW'(1);
   assign cnt_x     = XW'(count_ff);
   assign r_ok      = right < cnt_x;
   assign l_gt      = a_key > cur_key_ff;
   assign pick_r    = r_ok && (b_key > (l_gt ? a_key : cur_key_ff));

   always_comb begin
      err_code = ST_OK;
      case (op_ff)
         OP_INSERT: begin
            if (!id_ok_ff) err_code = ST_ABSENT;
            else if (pos_hit_ff) err_code = ST_PRESENT;
            else if (count_ff == CW'(HEAP_DEPTH)) err_code = ST_FULL;
         end
         OP_EXTRACT: begin
            if (count_ff == '0) err_code = ST_EMPTY;
         end
         default: begin
            if (!id_ok_ff || !pos_hit_ff) err_code = ST_ABSENT;
         end
      endcase
   end

   always_comb begin
      sts            = '0;
      sts.err        = err_code != ST_OK;
      sts.is_insert  = op_ff == OP_INSERT;
      sts.fetch_done = (op_ff != OP_UPDATE) && (hole_ff == last_slot);
      if (op_ff == OP_REMOVE) sts.sift_up = b_key > a_key;
      else if (op_ff == OP_UPDATE) sts.sift_up = !(key_ff < a_key);
      sts.at_top     = hole_ff == '0;
      sts.at_leaf    = left >= cnt_x;
      sts.up_move    = cur_key_ff > a_key;
      sts.dn_move    = l_gt || pick_r;
   end

   // read addresses
   always_comb begin
      rd_en  = 1'b0;
      addr_a = parent;
      addr_b = last_slot;
      case (step_code)
         STEP_SETUP: begin
            rd_en  = 1'b1;
            addr_a = (op_ff == OP_EXTRACT) ? '0 : pos_rd_ff;
         end
         STEP_UP_RD: begin
            rd_en  = 1'b1;
         end
         STEP_DN_RD: begin
            rd_en  = 1'b1;
            addr_a = left[AW-1:0];
            addr_b = right[AW-1:0];
         end
         default: rd_en = 1'b0;
      endcase
   end

   // hole write: whatever lands in the hole also gets its position updated
   always_comb begin
      slot_we = 1'b0;
      slot_wd = {cur_item_ff, cur_key_ff};
      hole_in = hole_ff;
      count_in = count_ff;
      case (step_code)
         STEP_SETUP: begin
            if (op_ff == OP_INSERT) hole_in = AW'(count_ff);
            else if (op_ff == OP_EXTRACT) hole_in = '0;
            else hole_in = pos_rd_ff;
            if (op_ff == OP_INSERT && err_code == ST_OK) count_in = count_ff + CW'(1);
         end
         STEP_FETCH: begin
            if (op_ff != OP_UPDATE) count_in = count_ff - CW'(1);
         end
         STEP_UP_CMP: begin
            if (sts.up_move) begin
               slot_we = 1'b1;
               slot_wd = rd_a_ff;
               hole_in = parent;
            end
         end
         STEP_DN_CMP: begin
            if (sts.dn_move) begin
               slot_we = 1'b1;
               slot_wd = pick_r ? rd_b_ff : rd_a_ff;
               hole_in = pick_r ? right[AW-1:0] : left[AW-1:0];
            end
         end
         STEP_PLACE: slot_we = 1'b1;
         default: slot_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[hole_ff] <= slot_wd;
         pos_mem[slot_wd[KEY_BITS+IW-1:KEY_BITS]] <= hole_ff;
      end
      if (rd_en) begin
         rd_a_ff <= slot_mem[addr_a];
         rd_b_ff <= slot_mem[addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         pos_vld_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (step_code == STEP_FETCH && op_ff != OP_UPDATE)
            pos_vld_ff[a_item[IW-1:0]] <= 1'b0;
         if (step_code == STEP_PLACE)
            pos_vld_ff[cur_item_ff[IW-1:0]] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      hole_ff <= hole_in;
      case (step_code)
         STEP_CAPTURE: begin
            op_ff      <= req_op;
            item_ff    <= req_item_id;
            key_ff     <= KEY_BITS'(req_key);
            id_ok_ff   <= 32'(req_item_id) < 32'(ITEM_COUNT);
            pos_rd_ff  <= pos_mem[req_item_id[IW-1:0]];
            pos_hit_ff <= pos_vld_ff[req_item_id[IW-1:0]];
         end
         STEP_SETUP: begin
            status_ff   <= err_code;
            out_item_ff <= '0;
            out_key_ff  <= '0;
            cur_key_ff  <= key_ff;
            cur_item_ff <= item_ff;
         end
         STEP_FETCH: begin
            if (op_ff != OP_UPDATE) begin
               out_item_ff <= a_item;
               out_key_ff  <= a_key;
               cur_key_ff  <= b_key;
               cur_item_ff <= rd_b_ff[SW-1:KEY_BITS];
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_status      = status_ff;
   assign rsp_out_item    = out_item_ff;
   assign rsp_out_key     = 32'(out_key_ff);
   assign rsp_entry_total = 9'(count_ff);

   `IMHQ_ASSERT_HOLDS(a_count_range, clock, reset, count_ff <= CW'(HEAP_DEPTH), "count over depth")
   `IMHQ_ASSERT_HOLDS(a_place_inside, clock, reset, (step_code != STEP_PLACE) || (CW'(hole_ff) < count_ff), "hole outside heap")

endmodule

/* rtl/core/imhq_ctrl.sv */
// ----------------------------------------------------------------------------
// imhq_ctrl
// Sequencer: steps the datapath through lookup, fetch, sift and placement.
// ----------------------------------------------------------------------------
`include "indexed_max_heap_queue_top_macros.svh"

module imhq_ctrl import imhq_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  imhq_sts_type       sts,
   output logic [STEP_W-1:0]  step_code
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SETUP  = 4'd1;
   localparam logic [3:0] S_FETCH  = 4'd2;
   localparam logic [3:0] S_UP_RD  = 4'd3;
   localparam logic [3:0] S_UP_CMP = 4'd4;
   localparam logic [3:0] S_DN_RD  = 4'd5;
   localparam logic [3:0] S_DN_CMP = 4'd6;
   localparam logic [3:0] S_PLACE  = 4'd7;
   localparam logic [3:0] S_RESP   = 4'd8;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      step_code = STEP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               step_code = STEP_CAPTURE;
               state_in  = S_SETUP;
            end
         end
         S_SETUP: begin
            step_code = STEP_SETUP;
            if (sts.err) state_in = S_RESP;
            else if (sts.is_insert) state_in = S_UP_RD;
            else state_in = S_FETCH;
         end
         S_FETCH: begin
            step_code = STEP_FETCH;
            if (sts.fetch_done) state_in = S_RESP;
            else if (sts.sift_up) state_in = S_UP_RD;
            else state_in = S_DN_RD;
         end
         S_UP_RD: begin
            step_code = STEP_UP_RD;
            state_in  = sts.at_top ? S_PLACE : S_UP_CMP;
         end
         S_UP_CMP: begin
            step_code = STEP_UP_CMP;
            state_in  = sts.up_move ? S_UP_RD : S_PLACE;
         end
         S_DN_RD: begin
            step_code = STEP_DN_RD;
            state_in  = sts.at_leaf ? S_PLACE : S_DN_CMP;
         end
         S_DN_CMP: begin
            step_code = STEP_DN_CMP;
            state_in  = sts.dn_move ? S_DN_RD : S_PLACE;
         end
         S_PLACE: begin
            step_code = STEP_PLACE;
            state_in  = S_RESP;
         end
         S_RESP: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = state_ff == S_RESP;

   `IMHQ_ASSERT_NEXT(a_busy_after_beat, clock, reset, req_valid && !req_stall, req_stall && !rsp_valid, "no setup after accept")
   `IMHQ_ASSERT_HOLDS(a_one_in_flight, clock, reset, !(rsp_valid && !req_stall), "request open while result pending")

endmodule

/* dv/tb_indexed_max_heap_queue_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for indexed_max_heap_queue_top
// Drives insert, extract, remove and update requests with random gaps on the
// request side and random stalls on the result side. A heap model with its own
// slot and position tables predicts each result beat, and a scoreboard
// compares every field.
// ----------------------------------------------------------------------------
import imhq_pkg::*;

class heap_scoreboard;
   logic [31:0] heap_key[256];
   logic [7:0]  heap_item[256];
   int          slot_of[256];   // -1 when the item is not in the heap
   int          fill;
   logic [2:0]  want_status[$];
   logic [7:0]  want_item[$];
   logic [31:0] want_key[$];
   logic [8:0]  want_total[$];
   int          errors;

   function void clear();
      for (int i = 0; i < 256; i++) slot_of[i] = -1;
      fill = 0;
      errors = 0;
   endfunction

   function void swap_slots(int a, int b);
      logic [31:0] k;
      logic [7:0]  it;
      k = heap_key[a]; it = heap_item[a];
      heap_key[a] = heap_key[b]; heap_item[a] = heap_item[b];
      heap_key[b] = k; heap_item[b] = it;
      slot_of[heap_item[a]] = a;
      slot_of[heap_item[b]] = b;
   endfunction

   function void sift_up(int s);
      int p;
      while (s > 0 && s < fill) begin
         p = (s - 1) / 2;
         if (heap_key[s] <= heap_key[p]) break;
         swap_slots(s, p);
         s = p;
      end
   endfunction

   function void sift_down(int s);
      int best;
      while (s < fill) begin
         best = s;
         if (2*s+1 < fill && heap_key[2*s+1] > heap_key[best]) best = 2*s+1;
         if (2*s+2 < fill && heap_key[2*s+2] > heap_key[best]) best = 2*s+2;
         if (best == s) break;
         swap_slots(s, best);
         s = best;
      end
   endfunction

   // apply one accepted request beat and queue the result it must produce
   function void note_request(logic [1:0] op, logic [7:0] id, logic [31:0] key);
      logic [2:0]  st;
      logic [7:0]  got_item;
      logic [31:0] got_key;
      logic [31:0] old;
      int          pos;
      int          last;
      st = ST_OK; got_item = 0; got_key = 0;
      pos = slot_of[id];
      if (pos >= fill) pos = -1;
      case (op)
         OP_INSERT: begin
            if (pos >= 0) st = ST_PRESENT;
            else if (fill >= 256) st = ST_FULL;
            else begin
               heap_key[fill] = key; heap_item[fill] = id; slot_of[id] = fill;
               fill++;
               sift_up(fill - 1);
            end
         end
         OP_EXTRACT: begin
            if (fill == 0) st = ST_EMPTY;
            else begin
               got_item = heap_item[0]; got_key = heap_key[0];
               swap_slots(0, fill - 1);
               fill--;
               sift_down(0);
               slot_of[got_item] = -1;
            end
         end
         OP_REMOVE: begin
            if (pos < 0) st = ST_ABSENT;
            else begin
               last = fill - 1;
               got_item = heap_item[pos]; got_key = heap_key[pos];
               swap_slots(pos, last);
               fill = last;
               if (pos < fill) begin
                  if (heap_key[pos] > got_key) sift_up(pos);
                  else sift_down(pos);
               end
               slot_of[got_item] = -1;
            end
         end
         default: begin
            if (pos < 0) st = ST_ABSENT;
            else begin
               old = heap_key[pos];
               heap_key[pos] = key;
               if (key < old) sift_down(pos);
               else sift_up(pos);
            end
         end
      endcase
      want_status.push_back(st);
      want_item.push_back(got_item);
      want_key.push_back(got_key);
      want_total.push_back(fill[8:0]);
   endfunction

   function void check_result(logic [2:0] st, logic [7:0] it, logic [31:0] k,
                              logic [8:0] tot);
      if (want_status.size() == 0) begin
         errors++;
         if (errors <= 10) $display("unexpected result beat: status %0d", st);
         return;
      end
      if (st !== want_status[0] || it !== want_item[0] || k !== want_key[0] ||
          tot !== want_total[0]) begin
         errors++;
         if (errors <= 10)
            $display("mismatch: exp st=%0d item=%0d key=%h total=%0d, got st=%0d item=%0d key=%h total=%0d",
                     want_status[0], want_item[0], want_key[0], want_total[0],
                     st, it, k, tot);
      end
      void'(want_status.pop_front());
      void'(want_item.pop_front());
      void'(want_key.pop_front());
      void'(want_total.pop_front());
   endfunction
endclass

module tb_indexed_max_heap_queue_top;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_op = OP_INSERT;
   logic [7:0]  req_item_id = '0;
   logic [31:0] req_key = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_out_item;
   logic [31:0] rsp_out_key;
   logic [8:0]  rsp_entry_total;

   heap_scoreboard heap_sb;
   int          cycles = 0;
   int          stall_left = 0;
   bit          drain_mode = 0;   // receiver stays ready while filling/draining

   // sized for ~1600 beats plus long gaps and stalls, times several
   localparam int CYCLE_LIMIT = 1000000;

   always #6 clock = ~clock;

   indexed_max_heap_queue_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_op(req_op),
      .req_item_id(req_item_id), .req_key(req_key),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_out_item(rsp_out_item), .rsp_out_key(rsp_out_key),
      .rsp_entry_total(rsp_entry_total)
   );

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // result side: check accepted beats, stall in runs of random length
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            heap_sb.check_result(rsp_status, rsp_out_item, rsp_out_key, rsp_entry_total);
         if (drain_mode) begin
            rsp_stall  <= 1'b0;
            stall_left <= 0;
         end else if (stall_left > 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= stall_left - 1;
         end else if ($urandom_range(0, 99) < 30) begin
            rsp_stall  <= 1'b1;
            stall_left <= gap_len();
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // timeout watchdog
   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout");
         $display("*** FAILED ***");
         $finish;
      end
   end

   // one request beat; the scoreboard sees it at the edge it is taken
   task automatic send_beat(logic [1:0] op, logic [7:0] id, logic [31:0] key);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_op      <= op;
      req_item_id <= id;
      req_key     <= key;
      do @(posedge clock); while (req_stall);
      heap_sb.note_request(op, id, key);
   endtask

   // random key, weighted toward a few values so ties happen
   function automatic logic [31:0] rand_key();
      int r;
      r = $urandom_range(0, 9);
      if (r < 3) return $urandom_range(0, 7);
      if (r == 3) return 32'hFFFF_FFFF;
      return $urandom;
   endfunction

   // small id pool keeps hits on present items frequent
   function automatic logic [7:0] rand_id(int pool);
      if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(0, pool - 1));
   endfunction

   initial begin
      int pool;
      int op_pick;
      int settle;
      heap_sb = new();
      heap_sb.clear();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty cases, extremes, ties, every op
      send_beat(OP_EXTRACT, 8'd0,   32'd0);
      send_beat(OP_REMOVE,  8'd5,   32'd0);
      send_beat(OP_UPDATE,  8'd255, 32'hFFFF_FFFF);
      send_beat(OP_INSERT,  8'd0,   32'd0);
      send_beat(OP_INSERT,  8'd255, 32'hFFFF_FFFF);
      send_beat(OP_INSERT,  8'd255, 32'd1);          // already present
      send_beat(OP_INSERT,  8'hAA,  32'hAAAA_AAAA);
      send_beat(OP_INSERT,  8'h55,  32'h5555_5555);
      send_beat(OP_INSERT,  8'd7,   32'h5555_5555);  // tie
      send_beat(OP_UPDATE,  8'd0,   32'hFFFF_FFFF);  // up, tie with top
      send_beat(OP_UPDATE,  8'd255, 32'd3);          // down
      send_beat(OP_REMOVE,  8'd7,   32'd0);          // last slot
      send_beat(OP_REMOVE,  8'hAA,  32'd0);
      send_beat(OP_EXTRACT, 8'd0,   32'd0);
      send_beat(OP_EXTRACT, 8'd0,   32'd0);
      send_beat(OP_EXTRACT, 8'd0,   32'd0);
      send_beat(OP_EXTRACT, 8'd0,   32'd0);          // empty again

      // fill to full, probe full, then drain completely
      drain_mode = 1;
      for (int i = 0; i < 256; i++) send_beat(OP_INSERT, i[7:0], rand_key());
      send_beat(OP_INSERT, 8'd3, 32'd9);             // present wins over full
      heap_sb.slot_of[0] = heap_sb.slot_of[0];
      send_beat(OP_REMOVE, 8'd100, 32'd0);
      send_beat(OP_INSERT, 8'd200, 32'd1);
      send_beat(OP_INSERT, 8'd100, 32'd1);           // succeeds, heap full again
      for (int i = 0; i < 257; i++) send_beat(OP_EXTRACT, 8'd0, 32'd0);
      drain_mode = 0;

      // random mix; pool size varies to swing between sparse and dense heaps
      for (int n = 0; n < 1070; n++) begin
         if (n % 200 == 0) pool = $urandom_range(4, 256);
         op_pick = $urandom_range(0, 99);
         if (op_pick < 40)
            send_beat(OP_INSERT, rand_id(pool), rand_key());
         else if (op_pick < 60)
            send_beat(OP_EXTRACT, 8'($urandom), $urandom);
         else if (op_pick < 80)
            send_beat(OP_REMOVE, rand_id(pool), $urandom);
         else
            send_beat(OP_UPDATE, rand_id(pool), rand_key());
         if (n % 400 == 399) drain_mode = ~drain_mode;
      end
      req_valid <= 1'b0;

      drain_mode = 0;
      while (heap_sb.want_status.size() != 0) @(posedge clock);
      settle = 40;
      repeat (settle) @(posedge clock);
      if (heap_sb.errors == 0 && heap_sb.want_status.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
